/* rtl/cst_pkg.sv */
// Shared constants, types and helpers of the current-sensed travel stop unit.
package cst_pkg;

  // Window geometry and field widths
  localparam int WINDOW_DEPTH = 7;
  localparam int CUR_W        = 12;
  localparam int ENTRY_W      = 13;
  localparam int ENTRY_MAX    = 4096;
  localparam int SUM_W        = $clog2(WINDOW_DEPTH * ENTRY_MAX + 1);
  localparam int SPEED_W      = 15;
  localparam int THR_W        = 12;
  localparam int TICKS_W      = 16;
  localparam int FILL_W       = 12;
  localparam int DRIVE_W      = 16;

  // Configuration port geometry
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_SPEED     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_FILL      = 2'd3;

  // Reset values
  localparam logic [SPEED_W-1:0] SPEED_RST     = 15'd300;
  localparam logic [THR_W-1:0]   THRESHOLD_RST = 12'd4;
  localparam logic [TICKS_W-1:0] TIMEOUT_RST   = 16'd50;
  localparam logic [FILL_W-1:0]  FILL_RST      = 12'd200;
  localparam int                 RESET_FILL    = 200;
  localparam logic [TICKS_W-1:0] TICKS_MAX     = '1;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_command;
    logic [THR_W-1:0]   stop_threshold;
    logic [TICKS_W-1:0] timeout_ticks;
    logic [FILL_W-1:0]  fill_value;
  } cst_cfg_t;

  typedef enum logic [2:0] {
    DIR_IDLE = 3'b001,
    DIR_UP   = 3'b010,
    DIR_DOWN = 3'b100
  } cst_dir_t;

  // Magnitude of a signed current sample; the most negative code maps to 2048
  function automatic logic [ENTRY_W-1:0] abs_current(input logic signed [CUR_W-1:0] v);
    logic [ENTRY_W-1:0] ext;
    ext = {v[CUR_W-1], v};
    return ext[ENTRY_W-1] ? (~ext + ENTRY_W'(1)) : ext;
  endfunction

endpackage

/* rtl/cst_ifs.sv */
// Valid/ready channel interfaces for sample/command transactions and drive results.
interface cst_in_if;
  import cst_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    func;
  logic                    direction_up;
  logic signed [CUR_W-1:0] current_ch0;
  logic signed [CUR_W-1:0] current_ch1;

  modport source (output valid, func, direction_up, current_ch0, current_ch1, input ready);
  modport sink   (input valid, func, direction_up, current_ch0, current_ch1, output ready);
endinterface

interface cst_out_if;
  import cst_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic                      stopped_now;

  modport source (output valid, drive, stopped_now, input ready);
  modport sink   (input valid, drive, stopped_now, output ready);
endinterface

/* rtl/cst_cfg_regs.sv */
// APB-style configuration register bank of the travel stop unit.
module cst_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cst_pkg::PADDR_W-1:0]   paddr,
  input  logic [cst_pkg::PDATA_W-1:0]   pwdata,
  output logic [cst_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output cst_pkg::cst_cfg_t             cfg
);
  import cst_pkg::*;

  cst_cfg_t               cfg_r;
  logic                   wr_en;
  logic [REG_IDX_W-1:0]   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[REG_IDX_W+1:2];
  assign cfg     = cfg_r;

  // Update the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_command  <= SPEED_RST;
      cfg_r.stop_threshold <= THRESHOLD_RST;
      cfg_r.timeout_ticks  <= TIMEOUT_RST;
      cfg_r.fill_value     <= FILL_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SPEED:     cfg_r.speed_command  <= pwdata[SPEED_W-1:0];
        REG_THRESHOLD: cfg_r.stop_threshold <= pwdata[THR_W-1:0];
        REG_TIMEOUT:   cfg_r.timeout_ticks  <= pwdata[TICKS_W-1:0];
        REG_FILL:      cfg_r.fill_value     <= pwdata[FILL_W-1:0];
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  // Return the addressed register, zero-extended
  always_comb begin
    case (reg_idx)
      REG_SPEED:     prdata = PDATA_W'(cfg_r.speed_command);
      REG_THRESHOLD: prdata = PDATA_W'(cfg_r.stop_threshold);
      REG_TIMEOUT:   prdata = PDATA_W'(cfg_r.timeout_ticks);
      REG_FILL:      prdata = PDATA_W'(cfg_r.fill_value);
      default:       prdata = '0;
    endcase
  end

endmodule

/* rtl/cst_window.sv */
// Current window shift line with a running sum of its entries.
module cst_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_en,
  input  logic [cst_pkg::ENTRY_W-1:0]   push_val,
  output logic [cst_pkg::SUM_W-1:0]     sum_after
);
  import cst_pkg::*;

  logic [ENTRY_W-1:0] win_r [WINDOW_DEPTH];
  logic [SUM_W-1:0]   sum_r;

  // Sum once the oldest entry drops out and the new one enters
  assign sum_after = sum_r - SUM_W'(win_r[WINDOW_DEPTH-1]) + SUM_W'(push_val);

  // Shift the window and hold the running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_r[i] <= ENTRY_W'(RESET_FILL);
      end
      sum_r <= SUM_W'(RESET_FILL * WINDOW_DEPTH);
    end else if (push_en) begin
      win_r[0] <= push_val;
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
        win_r[i] <= win_r[i-1];
      end
      sum_r <= sum_after;
    end
  end

endmodule

/* rtl/current_sensed_travel_stop_unit.sv */
// Top level of the current-sensed travel stop unit: motion control and result register.
//
// Takes one transaction per clock cycle, back to back, as long as the sink
// keeps taking results; a result that the sink holds off stalls the input
// until it drains. A command (func = 1) sets the direction and restarts the
// tick count and gives no result; a tick (func = 0) gives one result in the
// output register on the cycle after it is accepted. The whole tick, including
// the window running-sum update and the stop compare against threshold times
// window depth, is done between the input port and the result register, so
// throughput is one transaction per cycle. Window and settings are in
// flip-flops and are ready right out of reset.
module current_sensed_travel_stop_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  cst_in_if.sink                        in_if,
  cst_out_if.source                     out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cst_pkg::PADDR_W-1:0]   paddr,
  input  logic [cst_pkg::PDATA_W-1:0]   pwdata,
  output logic [cst_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import cst_pkg::*;

  cst_cfg_t             cfg;
  cst_dir_t             dir_r, dir_nxt;
  logic [TICKS_W-1:0]   ticks_r, ticks_nxt;
  logic                 out_valid_r;
  logic [DRIVE_W-1:0]   drive_r, drive_nxt;
  logic                 stopped_r, stopped_nxt;
  logic                 accept;
  logic                 tick_acc;
  logic                 moving;
  logic [ENTRY_W-1:0]   push_val;
  logic [SUM_W-1:0]     sum_after;
  logic [SUM_W-1:0]     stop_level;

  cst_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cst_window u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (tick_acc),
    .push_val  (push_val),
    .sum_after (sum_after)
  );

  // Accept whenever the result register is free or drains this cycle
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign tick_acc    = accept && !in_if.func;

  // Drive while a direction is set and the timeout has not run out
  assign moving     = (dir_r != DIR_IDLE) && (ticks_r < cfg.timeout_ticks);
  assign push_val   = moving ? (abs_current(in_if.current_ch0) + abs_current(in_if.current_ch1))
                             : ENTRY_W'(cfg.fill_value);
  assign stop_level = SUM_W'(cfg.stop_threshold) * SUM_W'(WINDOW_DEPTH);

  // Next direction, tick count and result for the incoming transaction
  always_comb begin
    dir_nxt     = dir_r;
    ticks_nxt   = ticks_r;
    drive_nxt   = '0;
    stopped_nxt = 1'b0;
    if (in_if.func) begin
      dir_nxt   = in_if.direction_up ? DIR_UP : DIR_DOWN;
      ticks_nxt = '0;
    end else begin
      if (moving) begin
        drive_nxt = (dir_r == DIR_UP) ? DRIVE_W'(cfg.speed_command)
                                      : -DRIVE_W'(cfg.speed_command);
        if (sum_after < stop_level) begin
          dir_nxt     = DIR_IDLE;
          stopped_nxt = 1'b1;
        end
      end
      if (ticks_r != TICKS_MAX) begin
        ticks_nxt = ticks_r + TICKS_W'(1);
      end
    end
  end

  // Advance motion state on every accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= DIR_IDLE;
      ticks_r <= TICKS_MAX;
    end else if (accept) begin
      dir_r   <= dir_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      drive_r   <= drive_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.drive       = signed'(drive_r);
  assign out_if.stopped_now = stopped_r;

endmodule
